### src/matrix_inverse_4x4_lu_top_defines.svh
// Assertion macros for the matrix inverse block.
`ifndef MATRIX_INVERSE_4X4_LU_TOP_DEFINES_SVH
`define MATRIX_INVERSE_4X4_LU_TOP_DEFINES_SVH
// Property that must hold whenever reset is released.
`define MI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Implication form of the same check.
`define MI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`endif

### src/mi_pkg.sv
package mi_pkg;
    localparam int DIM_DEF = 4;
    localparam int FRAC_DEF = 16;
    localparam int WW = 48;
    localparam logic signed [WW-1:0] W_MAX = {1'b0, {(WW-1){1'b1}}};
    localparam logic signed [WW-1:0] W_MIN = {1'b1, {(WW-1){1'b0}}};

    typedef enum logic [4:0] {
        ST_LOAD, ST_PIV_INIT, ST_PIV_SCAN, ST_SWAP, ST_PIV_CHK,
        ST_L_DIV, ST_L_DIV_WAIT, ST_UPD_MUL, ST_UPD_MUL_WAIT, ST_UPD_NEXT,
        ST_COL_NEXT, ST_S_INIT, ST_S_MUL, ST_S_MUL_WAIT, ST_F_NEXT,
        ST_B_MUL, ST_B_MUL_WAIT, ST_B_DIV, ST_B_DIV_WAIT, ST_B_NEXT,
        ST_STORE, ST_EMIT
    } state_t;

    typedef struct packed {
        logic start;
        logic signed [WW-1:0] a;
        logic signed [WW-1:0] b;
    } op_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic zero_div;
        logic signed [WW-1:0] res;
    } op_rsp_t;

    function automatic logic signed [WW-1:0] sat_sub(logic signed [WW-1:0] a,
                                                     logic signed [WW-1:0] b);
        logic signed [WW:0] d;
        d = {a[WW-1], a} - {b[WW-1], b};
        if (d > $signed({W_MAX[WW-1], W_MAX})) return W_MAX;
        if (d < $signed({W_MIN[WW-1], W_MIN})) return W_MIN;
        return d[WW-1:0];
    endfunction

    function automatic logic [WW-1:0] mag(logic signed [WW-1:0] v);
        return v[WW-1] ? (~v + 1'b1) : v;
    endfunction
endpackage

### src/mi_stream_if.sv
interface mi_stream_if #(parameter int W = 8);
    logic valid;
    logic ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### src/matrix_inverse_4x4_lu_top.sv
// Matrix inverse by LU factoring with partial pivoting, signed fixed point.
// Input channel in_ch carries {elem_index, elem_value}; one transfer loads one
// element at its row-major position, and positions outside the matrix are dropped.
// When DIM*DIM elements have been taken the block factors the matrix, solves
// against each permuted unit vector, and streams the DIM*DIM inverse elements
// on out_ch as {out_index, out_value, singular, last_out}, last_out on the final one.
// All multiplies and divides go through one shared unit: a multiply forms
// four 24x24 partial products, and a divide produces one quotient bit per
// cycle. For DIM=4 that is 22 divides and 62 multiplies per matrix.
// Loading runs at one element per cycle; in_ch is not ready while computing
// or emitting. If the receiver stalls, the current result holds on out_ch
// until its transfer. Reset clears the sequencer, the load count and the
// row order; the working matrix is undefined until loaded.
module matrix_inverse_4x4_lu_top
    import mi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_DEF
)
(
    input logic clk,
    input logic rst_n,
    mi_stream_if.sink in_ch,
    mi_stream_if.source out_ch
);
`include "matrix_inverse_4x4_lu_top_defines.svh"
    localparam int DIM = DIM_DEF;
    localparam int NE = DIM * DIM;
    localparam int DB = $clog2(DIM);
    localparam int EB = $clog2(NE);
    localparam int CB = $clog2(NE + 1);

    state_t state_reg, state_next;
    logic signed [WW-1:0] wm_reg [NE];
    logic signed [WW-1:0] wm_next [NE];
    logic [DB-1:0] ro_reg [DIM];
    logic [DB-1:0] ro_next [DIM];
    logic signed [WW-1:0] sv_reg [DIM];
    logic signed [WW-1:0] sv_next [DIM];
    logic signed [WW-1:0] inv_reg [NE];
    logic signed [WW-1:0] inv_next [NE];
    logic [CB-1:0] cnt_reg, cnt_next;
    logic [DB:0] j_reg, j_next, i_reg, i_next, k_reg, k_next, c_reg, c_next;
    logic [DB-1:0] piv_reg, piv_next;
    logic [WW-1:0] best_reg, best_next;
    logic zp_reg, zp_next;
    logic [EB-1:0] oi_reg, oi_next;
    logic is_div;
    op_req_t req;
    op_rsp_t rsp;
    logic [3:0] in_idx;
    logic signed [31:0] in_val, out_val;
    logic signed [WW-1:0] ov;

    assign in_idx = in_ch.data[35:32];
    assign in_val = in_ch.data[31:0];
    assign in_ch.ready = (state_reg == ST_LOAD);

    mi_muldiv #(.FRAC_BITS(FRAC_BITS)) u_unit
    (
        .clk(clk), .rst_n(rst_n), .is_div(is_div), .req(req), .rsp(rsp)
    );

    function automatic logic [EB-1:0] ix(logic [DB:0] r, logic [DB:0] c);
        return EB'(int'(r) * DIM + int'(c));
    endfunction

    always_comb
    begin
        state_next = state_reg;
        wm_next = wm_reg; ro_next = ro_reg; sv_next = sv_reg; inv_next = inv_reg;
        cnt_next = cnt_reg; j_next = j_reg; i_next = i_reg; k_next = k_reg;
        c_next = c_reg; piv_next = piv_reg; best_next = best_reg; zp_next = zp_reg;
        oi_next = oi_reg;
        is_div = 1'b0; req = '0;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_ch.valid && int'(in_idx) < NE)
                begin
                    wm_next[in_idx[EB-1:0]] = WW'(in_val);
                    if (cnt_reg == CB'(NE - 1))
                    begin
                        cnt_next = '0; zp_next = 1'b0; j_next = '0;
                        for (int n = 0; n < DIM; n++) ro_next[n] = DB'(n);
                        state_next = ST_PIV_INIT;
                    end
                    else cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_PIV_INIT:
            begin
                best_next = mag(wm_reg[ix(j_reg, j_reg)]);
                piv_next = j_reg[DB-1:0];
                i_next = j_reg + 1'b1;
                state_next = ST_PIV_SCAN;
            end
            ST_PIV_SCAN:
            begin
                if (int'(i_reg) >= DIM) state_next = ST_SWAP;
                else
                begin
                    if (mag(wm_reg[ix(i_reg, j_reg)]) > best_reg)
                    begin
                        best_next = mag(wm_reg[ix(i_reg, j_reg)]);
                        piv_next = i_reg[DB-1:0];
                    end
                    i_next = i_reg + 1'b1;
                end
            end
            ST_SWAP:
            begin
                for (int n = 0; n < DIM; n++)
                begin
                    wm_next[EB'(int'(j_reg) * DIM + n)] = wm_reg[EB'(int'(piv_reg) * DIM + n)];
                    wm_next[EB'(int'(piv_reg) * DIM + n)] = wm_reg[EB'(int'(j_reg) * DIM + n)];
                end
                ro_next[j_reg[DB-1:0]] = ro_reg[piv_reg];
                ro_next[piv_reg] = ro_reg[j_reg[DB-1:0]];
                state_next = ST_PIV_CHK;
            end
            ST_PIV_CHK:
            begin
                i_next = j_reg + 1'b1;
                if (wm_reg[ix(j_reg, j_reg)] == '0)
                begin
                    zp_next = 1'b1; state_next = ST_COL_NEXT;
                end
                else state_next = ST_L_DIV;
            end
            ST_L_DIV:
            begin
                is_div = 1'b1; req.start = 1'b1;
                req.a = wm_reg[ix(i_reg, j_reg)]; req.b = wm_reg[ix(j_reg, j_reg)];
                state_next = ST_L_DIV_WAIT;
            end
            ST_L_DIV_WAIT:
            begin
                is_div = 1'b1;
                if (rsp.done)
                begin
                    wm_next[ix(i_reg, j_reg)] = rsp.res;
                    k_next = j_reg + 1'b1;
                    state_next = ST_UPD_MUL;
                end
            end
            ST_UPD_MUL:
            begin
                req.start = 1'b1;
                req.a = wm_reg[ix(i_reg, j_reg)]; req.b = wm_reg[ix(j_reg, k_reg)];
                state_next = ST_UPD_MUL_WAIT;
            end
            ST_UPD_MUL_WAIT:
            begin
                if (rsp.done)
                begin
                    wm_next[ix(i_reg, k_reg)] = sat_sub(wm_reg[ix(i_reg, k_reg)], rsp.res);
                    k_next = k_reg + 1'b1;
                    state_next = (int'(k_reg) == DIM - 1) ? ST_UPD_NEXT : ST_UPD_MUL;
                end
            end
            ST_UPD_NEXT:
            begin
                i_next = i_reg + 1'b1;
                state_next = (int'(i_reg) == DIM - 1) ? ST_COL_NEXT : ST_L_DIV;
            end
            ST_COL_NEXT:
            begin
                j_next = j_reg + 1'b1;
                c_next = '0;
                state_next = (int'(j_reg) == DIM - 2) ? ST_S_INIT : ST_PIV_INIT;
            end
            ST_S_INIT:
            begin
                for (int n = 0; n < DIM; n++)
                    sv_next[n] = (ro_reg[n] == c_reg[DB-1:0]) ?
                        (WW'(1) << FRAC_BITS) : '0;
                i_next = (DB+1)'(1); k_next = '0;
                state_next = ST_F_NEXT;
            end
            ST_F_NEXT:
            begin
                if (int'(i_reg) >= DIM)
                begin
                    i_next = (DB+1)'(DIM - 1); k_next = (DB+1)'(DIM - 1);
                    state_next = ST_B_NEXT;
                end
                else if (k_reg < i_reg) state_next = ST_S_MUL;
                else
                begin
                    i_next = i_reg + 1'b1; k_next = '0;
                end
            end
            ST_S_MUL:
            begin
                req.start = 1'b1;
                req.a = wm_reg[ix(i_reg, k_reg)]; req.b = sv_reg[k_reg[DB-1:0]];
                state_next = ST_S_MUL_WAIT;
            end
            ST_S_MUL_WAIT:
            begin
                if (rsp.done)
                begin
                    sv_next[i_reg[DB-1:0]] = sat_sub(sv_reg[i_reg[DB-1:0]], rsp.res);
                    k_next = k_reg + 1'b1;
                    state_next = ST_F_NEXT;
                end
            end
            ST_B_NEXT:
            begin
                if (k_reg > i_reg) state_next = ST_B_MUL;
                else state_next = ST_B_DIV;
            end
            ST_B_MUL:
            begin
                req.start = 1'b1;
                req.a = wm_reg[ix(i_reg, k_reg)]; req.b = sv_reg[k_reg[DB-1:0]];
                state_next = ST_B_MUL_WAIT;
            end
            ST_B_MUL_WAIT:
            begin
                if (rsp.done)
                begin
                    sv_next[i_reg[DB-1:0]] = sat_sub(sv_reg[i_reg[DB-1:0]], rsp.res);
                    k_next = k_reg - 1'b1;
                    state_next = ST_B_NEXT;
                end
            end
            ST_B_DIV:
            begin
                is_div = 1'b1; req.start = 1'b1;
                req.a = sv_reg[i_reg[DB-1:0]]; req.b = wm_reg[ix(i_reg, i_reg)];
                state_next = ST_B_DIV_WAIT;
            end
            ST_B_DIV_WAIT:
            begin
                is_div = 1'b1;
                if (rsp.done)
                begin
                    sv_next[i_reg[DB-1:0]] = rsp.res;
                    if (rsp.zero_div) zp_next = 1'b1;
                    if (i_reg == '0) state_next = ST_STORE;
                    else
                    begin
                        i_next = i_reg - 1'b1; k_next = (DB+1)'(DIM - 1);
                        state_next = ST_B_NEXT;
                    end
                end
            end
            ST_STORE:
            begin
                for (int n = 0; n < DIM; n++)
                    inv_next[EB'(n * DIM + int'(c_reg))] = sv_reg[n];
                c_next = c_reg + 1'b1; oi_next = '0;
                state_next = (int'(c_reg) == DIM - 1) ? ST_EMIT : ST_S_INIT;
            end
            ST_EMIT:
            begin
                if (out_ch.ready)
                begin
                    oi_next = oi_reg + 1'b1;
                    if (int'(oi_reg) == NE - 1) state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg <= '0;
            zp_reg <= 1'b0;
            for (int n = 0; n < DIM; n++) ro_reg[n] <= DB'(n);
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            zp_reg <= zp_next;
            ro_reg <= ro_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wm_reg <= wm_next; sv_reg <= sv_next; inv_reg <= inv_next;
        j_reg <= j_next; i_reg <= i_next; k_reg <= k_next; c_reg <= c_next;
        piv_reg <= piv_next; best_reg <= best_next; oi_reg <= oi_next;
    end

    // Final clamp from the working width to the 32-bit output word.
    assign ov = inv_reg[oi_reg];
    always_comb
    begin
        if (ov > WW'(32'sh7FFF_FFFF)) out_val = 32'sh7FFF_FFFF;
        else if (ov < -WW'(33'sh0_8000_0000)) out_val = 32'sh8000_0000;
        else out_val = ov[31:0];
    end

    assign out_ch.valid = (state_reg == ST_EMIT);
    assign out_ch.data = {4'(oi_reg), out_val, zp_reg, (int'(oi_reg) == NE - 1)};

    // The input side is closed whenever results are offered.
    `MI_ASSERT(a_no_overlap, !(in_ch.ready && out_ch.valid), "input open during output")
    // The shared unit is never restarted while it is still busy.
    `MI_ASSERT_IMP(a_unit_free, req.start, !rsp.busy, "unit restarted while busy")
    // A stalled result must not change index.
    `MI_ASSERT_IMP(a_hold, out_ch.valid && !out_ch.ready, ##1 $stable(oi_reg), "result moved")
endmodule

### src/mi_muldiv.sv
module mi_muldiv
    import mi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic is_div,
    input  op_req_t req,
    output op_rsp_t rsp
);
    localparam int QB = WW + FRAC_BITS;
    localparam int CW = $clog2(QB + 4);
    localparam logic [WW-1:0] MAGMAX = {1'b0, {(WW-1){1'b1}}};

    logic [WW-1:0] ma_reg, mb_reg, ma_next, mb_next;
    logic [WW-1:0] r_reg, r_next;
    logic [WW:0] q_reg, q_next;
    logic [2*WW-1:0] acc_reg, acc_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic neg_reg, neg_next, div_reg, div_next, busy_reg, busy_next;
    logic done_reg, done_next, zd_reg, zd_next;
    logic signed [WW-1:0] res_reg, res_next;
    logic [23:0] pa, pb;
    logic [47:0] pp;
    logic [WW:0] rs;
    logic [WW-1:0] m;
    logic [QB-1:0] nsh;

    assign pa = ma_reg[cnt_reg[1] * 24 +: 24];
    assign pb = mb_reg[cnt_reg[0] * 24 +: 24];
    assign pp = pa * pb;
    assign nsh = {ma_reg, {FRAC_BITS{1'b0}}};

    always_comb
    begin
        ma_next = ma_reg; mb_next = mb_reg; r_next = r_reg; q_next = q_reg;
        acc_next = acc_reg; cnt_next = cnt_reg; neg_next = neg_reg;
        div_next = div_reg; busy_next = busy_reg; done_next = 1'b0;
        zd_next = zd_reg; res_next = res_reg;
        rs = '0; m = '0;
        if (req.start)
        begin
            ma_next = mag(req.a); mb_next = mag(req.b);
            neg_next = req.a[WW-1] ^ req.b[WW-1];
            div_next = is_div; cnt_next = '0; acc_next = '0;
            r_next = '0; q_next = '0; zd_next = 1'b0;
            if (is_div && req.b == '0)
            begin
                zd_next = 1'b1; res_next = '0; done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (!div_reg)
            begin
                acc_next = acc_reg + ({{WW{1'b0}}, pp} << ((cnt_reg[1] + cnt_reg[0]) * 24));
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(3))
                begin
                    busy_next = 1'b0; done_next = 1'b1;
                    if (acc_next[2*WW-1:WW+FRAC_BITS-1] != '0) m = MAGMAX;
                    else m = acc_next[FRAC_BITS +: WW];
                    res_next = neg_reg ? -m : m;
                end
            end
            else
            begin
                rs = {r_reg, nsh[QB-1-cnt_reg]};
                // A quotient already at the cap stays there.
                q_next = q_reg[WW] ? q_reg : {q_reg[WW-1:0], 1'b0};
                if (rs >= {1'b0, mb_reg})
                begin
                    rs = rs - {1'b0, mb_reg};
                    q_next[0] = 1'b1;
                end
                if (q_next > (WW+1)'(1) << WW) q_next = (WW+1)'(1) << WW;
                r_next = rs[WW-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(QB-1))
                begin
                    busy_next = 1'b0; done_next = 1'b1;
                    m = (q_next > {1'b0, MAGMAX}) ? MAGMAX : q_next[WW-1:0];
                    res_next = neg_reg ? -m : m;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0; done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next; done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg <= ma_next; mb_reg <= mb_next; r_reg <= r_next; q_reg <= q_next;
        acc_reg <= acc_next; cnt_reg <= cnt_next; neg_reg <= neg_next;
        div_reg <= div_next; zd_reg <= zd_next; res_reg <= res_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.zero_div = zd_reg;
    assign rsp.res = res_reg;
endmodule
